// File: src/vca_pkg.sv
// types and constants shared by the voice channel allocator modules
`default_nettype none

package vca_pkg;

  // beat kinds on the input stream
  localparam logic [1:0] KIND_PLAY   = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // channels that masks and explicit choices can reach
  localparam int MASK_BITS = 4;

  // stored priority that can never be stolen
  localparam logic [7:0] PRIO_NONE = 8'hFF;

  typedef logic [7:0] prio_t;

  // one input beat, unpacked from tuser and tdata
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] channel_choice;
    logic [3:0] first_mask;
    logic [3:0] last_mask;
    prio_t      request_priority;
    logic [3:0] stop_mask;
    logic [1:0] finished_channel;
  } item_t;

  // allocation decision for a play request
  typedef struct packed {
    logic       grant;
    logic [1:0] channel;
  } grant_t;

endpackage

`default_nettype wire

// File: src/vca_pick.sv
// channel choice for a play request: explicit, idle search, or steal
`default_nettype none

module vca_pick #(
  parameter int NUM_CHANNELS = 4
) (
  input  vca_pkg::item_t          item,
  input  logic [3:0]              active,
  input  vca_pkg::prio_t [3:0]    prios,
  output vca_pkg::grant_t         decision
);
  import vca_pkg::*;

  localparam int REACH = (NUM_CHANNELS < MASK_BITS) ? NUM_CHANNELS : MASK_BITS;

  logic [3:0] reach;
  logic [3:0] idle_first;
  logic [3:0] idle_last;
  logic [3:0] steal_set;
  logic       hit_first;
  logic       hit_last;
  logic       hit_steal;
  logic [1:0] ch_first;
  logic [1:0] ch_last;
  logic [1:0] ch_steal;
  prio_t      min_prio;
  logic       explicit;

  // channels that exist below the mask width
  always_comb begin
    for (int j = 0; j < MASK_BITS; j++) begin
      reach[j] = (j < REACH);
    end
  end

  assign explicit   = (item.channel_choice < 3'(REACH));
  assign idle_first = item.first_mask & ~active & reach;
  assign idle_last  = item.last_mask & ~active & reach;
  assign steal_set  = item.last_mask & reach;

  // highest-numbered idle channel in each mask
  always_comb begin
    hit_first = 1'b0;
    hit_last  = 1'b0;
    ch_first  = '0;
    ch_last   = '0;
    for (int j = 0; j < MASK_BITS; j++) begin
      if (idle_first[j]) begin
        hit_first = 1'b1;
        ch_first  = 2'(j);
      end
      if (idle_last[j]) begin
        hit_last = 1'b1;
        ch_last  = 2'(j);
      end
    end
  end

  // lowest-numbered channel holding the minimum priority below PRIO_NONE
  always_comb begin
    hit_steal = 1'b0;
    ch_steal  = '0;
    min_prio  = PRIO_NONE;
    for (int j = 0; j < MASK_BITS; j++) begin
      if (steal_set[j] && (prios[j] < min_prio)) begin
        hit_steal = 1'b1;
        ch_steal  = 2'(j);
        min_prio  = prios[j];
      end
    end
  end

  // final choice in priority order
  always_comb begin
    decision = '0;
    if (item.kind == KIND_PLAY) begin
      if (explicit) begin
        decision.grant   = 1'b1;
        decision.channel = item.channel_choice[1:0];
      end else if (hit_first) begin
        decision.grant   = 1'b1;
        decision.channel = ch_first;
      end else if (hit_last) begin
        decision.grant   = 1'b1;
        decision.channel = ch_last;
      end else if (hit_steal && (item.request_priority >= min_prio)) begin
        decision.grant   = 1'b1;
        decision.channel = ch_steal;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/voice_channel_allocator.sv
// top level of the voice channel allocator
`default_nettype none

// Takes one beat per cycle while the result register can drain and returns
// one result beat per input beat, through the input register and then the
// result register. The channel state is read and updated in the single step
// between those registers, so back-to-back beats see each other's effects
// with no stall. A beat of kind play gets a channel (explicit, idle in
// first_mask, idle in last_mask, else stolen by lowest priority from
// last_mask); stop and finish beats release channels. Only channels 0..3 are
// reachable by masks and choices; busy_map reports those.

module voice_channel_allocator #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kind
  input  logic [1:0]  s_tuser,
  // channel_choice[2:0], first_mask[6:3], last_mask[10:7], request_priority[18:11],
  // stop_mask[22:19], finished_channel[24:23], zero pad[31:25]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // granted
  output logic        m_tuser,
  // granted_channel[1:0], busy_map[5:2], zero pad[7:6]
  output logic [7:0]  m_tdata
);
  import vca_pkg::*;

  logic                    in_valid;
  item_t                   in_item;
  logic                    out_valid;
  logic                    res_granted;
  logic [1:0]              res_channel;
  logic [3:0]              res_busy;
  logic [NUM_CHANNELS-1:0] active;
  logic [NUM_CHANNELS-1:0] active_next;
  prio_t                   prio [NUM_CHANNELS];

  logic                    advance;
  logic                    fire;
  item_t                   s_item;
  logic [NUM_CHANNELS+3:0] active_pad;
  logic [NUM_CHANNELS+3:0] busy_pad;
  logic [NUM_CHANNELS+3:0] stop_pad;
  prio_t                   prio_pad [NUM_CHANNELS+4];
  prio_t [3:0]             prio_view;
  grant_t                  decision;

  // handshake: the result register frees as it drains
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign s_item = '{
    kind:             s_tuser,
    channel_choice:   s_tdata[2:0],
    first_mask:       s_tdata[6:3],
    last_mask:        s_tdata[10:7],
    request_priority: s_tdata[18:11],
    stop_mask:        s_tdata[22:19],
    finished_channel: s_tdata[24:23]
  };

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  // four-channel view of the state for the chooser
  assign active_pad = {4'b0, active};
  assign stop_pad   = {{NUM_CHANNELS{1'b0}}, in_item.stop_mask};

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS + 4; k++) begin
      prio_pad[k] = '0;
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      prio_pad[k] = prio[k];
    end
    for (int j = 0; j < MASK_BITS; j++) begin
      prio_view[j] = prio_pad[j];
    end
  end

  vca_pick #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_pick (
    .item     (in_item),
    .active   (active_pad[3:0]),
    .prios    (prio_view),
    .decision (decision)
  );

  // busy state after this beat
  always_comb begin
    active_next = active;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      case (in_item.kind)
        KIND_PLAY: begin
          if (decision.grant && (int'(decision.channel) == i)) begin
            active_next[i] = 1'b1;
          end
        end
        KIND_STOP: begin
          if (stop_pad[i]) begin
            active_next[i] = 1'b0;
          end
        end
        KIND_FINISH: begin
          if (int'(in_item.finished_channel) == i) begin
            active_next[i] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // busy map as seen on the four reachable channels
  assign busy_pad = {4'b0, active_next};

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prio[i] <= '0;
      end
    end else if (fire) begin
      active <= active_next;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (decision.grant && (int'(decision.channel) == i)) begin
          prio[i] <= in_item.request_priority;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_granted <= decision.grant;
      res_channel <= decision.channel;
      res_busy    <= busy_pad[3:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_granted;
  assign m_tdata  = {2'b0, res_busy, res_channel};

  // a granted channel shows as busy in the same beat
  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_granted |-> res_busy[res_channel])
    else $error("granted channel not marked busy");

  // stop, finish and unused-kind beats never grant
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.kind != KIND_PLAY) |=> !res_granted)
    else $error("grant on a non-play beat");

  // stopped channels are idle afterwards
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.kind == KIND_STOP) |=>
      ((active_pad[3:0] & $past(in_item.stop_mask)) == 4'b0))
    else $error("stopped channel still busy");

  // an empty result register never holds off the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// File: tb/tb_voice_channel_allocator.sv
// self-checking stream testbench for the voice channel allocator
`timescale 1ns / 1ps

module tb_voice_channel_allocator;
  import vca_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] CHOICE_AUTO = 3'd4;
  localparam int RANDOM_BEATS = 600;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;

  // one expected output beat
  typedef struct packed {
    logic       granted;
    logic [1:0] channel;
    logic [3:0] busy;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        m_tuser;
  logic [7:0]  m_tdata;

  voice_channel_allocator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // predicted channel state
  logic          voice_busy [MASK_BITS];
  prio_t         voice_prio [MASK_BITS];

  item_t         pending_beats [$];
  alloc_result_t expected_results [$];
  item_t         offered = '0;

  int errors = 0;
  int beats_sent = 0;
  int plays = 0;
  int grants = 0;
  int steals = 0;
  int releases = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  logic hold_on = 1'b0;
  logic hold_done = 1'b0;

  // highest idle channel in mask, or -1
  function automatic int idle_in(logic [3:0] mask);
    int found;
    found = -1;
    for (int i = 0; i < MASK_BITS; i++)
      if (mask[i] && !voice_busy[i]) found = i;
    return found;
  endfunction

  // apply one beat to the predicted state and return the expected output
  function automatic alloc_result_t allot_channel(item_t it);
    alloc_result_t res;
    int ch;
    int min_idx;
    logic [8:0] min_prio;
    res = '0;
    case (it.kind)
      KIND_PLAY: begin
        plays++;
        ch = -1;
        if (it.channel_choice < CHOICE_AUTO) begin
          ch = int'(it.channel_choice);
        end else begin
          ch = idle_in(it.first_mask);
          if (ch < 0) ch = idle_in(it.last_mask);
          if (ch < 0) begin
            // steal the lowest channel holding the smallest priority below none
            min_prio = {1'b0, PRIO_NONE};
            min_idx = -1;
            for (int i = 0; i < MASK_BITS; i++)
              if (it.last_mask[i] && {1'b0, voice_prio[i]} < min_prio) begin
                min_prio = {1'b0, voice_prio[i]};
                min_idx = i;
              end
            if (min_idx >= 0 && {1'b0, it.request_priority} >= min_prio) begin
              ch = min_idx;
              steals++;
            end
          end
        end
        if (ch >= 0) begin
          voice_busy[ch] = 1'b1;
          voice_prio[ch] = it.request_priority;
          res.granted = 1'b1;
          res.channel = ch[1:0];
          grants++;
        end
      end
      KIND_STOP: begin
        releases++;
        for (int i = 0; i < MASK_BITS; i++)
          if (it.stop_mask[i]) voice_busy[i] = 1'b0;
      end
      KIND_FINISH: begin
        releases++;
        voice_busy[it.finished_channel] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < MASK_BITS; i++) res.busy[i] = voice_busy[i];
    return res;
  endfunction

  function automatic item_t beat_of(logic [1:0] kind, logic [2:0] choice, logic [3:0] first,
                                    logic [3:0] last, prio_t prio, logic [3:0] stop,
                                    logic [1:0] fin);
    item_t it;
    it.kind = kind;
    it.channel_choice = choice;
    it.first_mask = first;
    it.last_mask = last;
    it.request_priority = prio;
    it.stop_mask = stop;
    it.finished_channel = fin;
    return it;
  endfunction

  // mostly no gap, some short, a few long; every fourth stretch runs without gaps
  function automatic int pick_gap(int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((idx / 50) % 4 == 1) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // source side: offer queued beats, predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(allot_channel(offered));
        beats_sent <= beats_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          s_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          item_t it;
          it = pending_beats.pop_front();
          offered <= it;
          s_tuser <= it.kind;
          s_tdata <= {7'b0, it.finished_channel, it.stop_mask, it.request_priority,
                      it.last_mask, it.first_mask, it.channel_choice};
          s_tvalid <= 1'b1;
          tx_wait <= pick_gap(beats_sent);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: granted=%0b data=%h",
                   $time, m_tuser, m_tdata);
          errors++;
        end else begin
          alloc_result_t exp_res;
          exp_res = expected_results.pop_front();
          if (m_tuser !== exp_res.granted) begin
            $display("%0t: granted mismatch: expected %0b, actual %0b",
                     $time, exp_res.granted, m_tuser);
            errors++;
          end
          if (m_tdata[1:0] !== exp_res.channel) begin
            $display("%0t: granted_channel mismatch: expected %0d, actual %0d",
                     $time, exp_res.channel, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[5:2] !== exp_res.busy) begin
            $display("%0t: busy_map mismatch: expected %b, actual %b",
                     $time, exp_res.busy, m_tdata[5:2]);
            errors++;
          end
        end
      end
      if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        m_tready <= 1'b0;
      end else if (hold_on) begin
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        int gap;
        gap = pick_gap(beats_sent + 25);
        rx_wait <= gap;
        m_tready <= (gap == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_on <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_on) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_on <= 1'b0;
        hold_done <= 1'b1;
      end
    end else if (!hold_done && beats_sent >= HOLD_AFTER) begin
      hold_on <= 1'b1;
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_t it;
    int r;
    for (int i = 0; i < MASK_BITS; i++) begin
      voice_busy[i] = 1'b0;
      voice_prio[i] = '0;
    end

    // directed: unused kind, refusals, idle search order, stealing, explicit, release
    pending_beats.push_back(beat_of(KIND_UNUSED, 3'd7, 4'hF, 4'hF, 8'hFF, 4'hF, 2'd3));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'h0, 4'h0, 8'h00, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'hF, 4'h0, 8'h10, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'hF, 4'hF, 8'h20, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'h0, 4'hF, 8'h05, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd5, 4'h3, 4'h0, 8'h05, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'hF, 4'hF, 8'h04, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd6, 4'hF, 4'hF, 8'h05, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd7, 4'h0, 4'hC, 8'hFF, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'h0, 4'h8, 8'hFF, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd0, 4'h0, 4'h0, 8'hFF, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd1, 4'hF, 4'hF, 8'hFF, 4'hF, 2'd3));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd2, 4'h0, 4'h0, 8'hFF, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'hF, 4'hF, 8'hFF, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_PLAY, 3'd3, 4'hF, 4'hF, 8'h00, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_FINISH, 3'd0, 4'h0, 4'h0, 8'h00, 4'h0, 2'd3));
    pending_beats.push_back(beat_of(KIND_FINISH, 3'd7, 4'hF, 4'hF, 8'hFF, 4'hF, 2'd0));
    pending_beats.push_back(beat_of(KIND_STOP, 3'd0, 4'h0, 4'h0, 8'h00, 4'h0, 2'd0));
    pending_beats.push_back(beat_of(KIND_STOP, 3'd7, 4'hF, 4'hF, 8'hFF, 4'h6, 2'd3));
    pending_beats.push_back(beat_of(KIND_STOP, 3'd0, 4'h0, 4'h0, 8'h00, 4'hF, 2'd0));
    pending_beats.push_back(beat_of(KIND_FINISH, 3'd0, 4'h0, 4'h0, 8'h00, 4'h0, 2'd1));
    pending_beats.push_back(beat_of(KIND_PLAY, CHOICE_AUTO, 4'hF, 4'hF, 8'h00, 4'h0, 2'd0));

    // random: play-heavy so channels fill up and stealing is reached often
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      it = '0;
      it.channel_choice = 3'($urandom_range(0, 7));
      it.first_mask = 4'($urandom_range(0, 15));
      it.last_mask = 4'($urandom_range(0, 15));
      it.stop_mask = 4'($urandom_range(0, 15));
      it.finished_channel = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      it.request_priority = (r == 0) ? 8'h00 : (r == 1) ? PRIO_NONE : prio_t'($urandom);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        it.kind = KIND_PLAY;
        if ($urandom_range(0, 3) != 0) it.channel_choice = 3'($urandom_range(4, 7));
        else it.channel_choice = 3'($urandom_range(0, 3));
      end else if (r < 75) begin
        it.kind = KIND_FINISH;
      end else if (r < 93) begin
        it.kind = KIND_STOP;
      end else begin
        it.kind = KIND_UNUSED;
      end
      pending_beats.push_back(it);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("covered %0d beats: %0d play requests, %0d granted, %0d by stealing",
             beats_sent, plays, grants, steals);
    $display("%0d stop or finish beats, one long receiver hold-off, %0d mismatches",
             releases, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
